>>> rtl/mpsd_pkg.sv
// Package for the Morse paddle symbol decoder.
// Holds the symbol codes, counter width and reset values shared by the RTL.
// No dependencies.
package mpsd_pkg;

  // Width of the saturating tick counter
  localparam int unsigned TickW = 20;

  // Width of the dit period register
  localparam int unsigned PeriodW = 16;

  // Reset value of the dit period register
  localparam logic [PeriodW-1:0] PeriodReset = 16'd60;

  // Symbol codes on the output port
  localparam logic [1:0] SymDit  = 2'd0;
  localparam logic [1:0] SymDah  = 2'd1;
  localparam logic [1:0] SymChar = 2'd2;
  localparam logic [1:0] SymWord = 2'd3;

  // Last-symbol codes, with an extra code for "nothing emitted yet"
  localparam logic [2:0] LastDit  = 3'd0;
  localparam logic [2:0] LastDah  = 3'd1;
  localparam logic [2:0] LastChar = 3'd2;
  localparam logic [2:0] LastWord = 3'd3;
  localparam logic [2:0] LastNone = 3'd4;

endpackage

>>> rtl/morse_paddle_symbol_decoder_top.sv
// Morse paddle symbol decoder, top level.
// Depends on mpsd_pkg for symbol codes, counter width and reset values.
// Single module: decode logic, state registers and the result register.

// Takes one dit/dah paddle sample per request and returns at most one Morse
// symbol (dit, dah, character space, word space) per sample. The block takes
// one request every clock cycle whenever its output register is empty or is
// being emptied in the same cycle: each sample is decided in the cycle it is
// accepted, from the recorded paddle state, the saturating tick counter and
// the lockout flags, and its symbol is written into a single output register.
// The user must set the dit period via cfg_we_i / cfg_wdata_i while no
// request is in flight; the block does not check it. It resets to 60 ticks;
// dit repeats and spaces trigger at two elapsed periods, dah repeats at four.
module morse_paddle_symbol_decoder_top (
  input  logic       clk_i,
  input  logic       rst_ni,
  // Configuration
  input  logic       cfg_we_i,
  input  logic [15:0] cfg_wdata_i,
  // Sample request
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic       dit_paddle_i,
  input  logic       dah_paddle_i,
  // Symbol result
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic [1:0] symbol_o
);

  localparam int unsigned TickW   = mpsd_pkg::TickW;
  localparam int unsigned PeriodW = mpsd_pkg::PeriodW;

  // State
  logic [PeriodW-1:0] period_q;
  logic               started_q, started_d;
  logic               prev_dit_q, prev_dit_d;
  logic               prev_dah_q, prev_dah_d;
  logic [TickW-1:0]   ticks_q, ticks_d;
  logic [2:0]         last_sym_q, last_sym_d;
  logic               dit_lock_q, dit_lock_d;
  logic               dah_lock_q, dah_lock_d;
  logic               out_valid_q, out_valid_d;
  logic [1:0]         symbol_q, symbol_d;

  // Decode signals
  logic             in_accept;
  logic [TickW-1:0] elapsed;
  logic [TickW-1:0] thresh2;
  logic [TickW-1:0] thresh4;
  logic             reach2;
  logic             reach4;
  logic             dit_eff;
  logic             dah_eff;
  logic             last_silent;
  logic             now_silent;
  logic             changed;
  logic             sym_valid;
  logic [1:0]       sym;

  assign in_ready_o  = !out_valid_q || out_ready_i;
  assign in_accept   = in_valid_i && in_ready_o;
  assign out_valid_o = out_valid_q;
  assign symbol_o    = symbol_q;

  // Saturating tick count and period thresholds
  always_comb begin
    elapsed = (ticks_q == {TickW{1'b1}}) ? ticks_q : ticks_q + 1'b1;
    thresh2 = TickW'({period_q, 1'b0});
    thresh4 = TickW'({period_q, 2'b00});
    reach2  = (elapsed >= thresh2);
    reach4  = (elapsed >= thresh4);
  end

  // Squeeze resolution, change detection and symbol choice
  always_comb begin
    dit_eff    = dit_paddle_i;
    dah_eff    = dah_paddle_i;
    dit_lock_d = dit_lock_q;
    dah_lock_d = dah_lock_q;
    last_silent = !prev_dit_q && !prev_dah_q;
    now_silent  = !dit_paddle_i && !dah_paddle_i;

    if (dit_paddle_i && dah_paddle_i) begin
      if (dit_lock_q) begin
        dit_eff = 1'b0;
      end else if (dah_lock_q) begin
        dah_eff = 1'b0;
      end else if (last_silent) begin
        dah_eff = 1'b0;
      end else if (prev_dit_q) begin
        dit_lock_d = 1'b1;
        dit_eff    = 1'b0;
      end else begin
        dah_lock_d = 1'b1;
        dah_eff    = 1'b0;
      end
    end else begin
      dit_lock_d = 1'b0;
      dah_lock_d = 1'b0;
    end

    changed = (last_silent && !now_silent) || (prev_dit_q && !dit_eff) ||
              (prev_dah_q && !dah_eff);

    sym_valid = 1'b0;
    sym       = mpsd_pkg::SymDit;
    if (changed) begin
      if (dit_eff) begin
        sym_valid = 1'b1;
        sym       = mpsd_pkg::SymDit;
      end else if (dah_eff) begin
        sym_valid = 1'b1;
        sym       = mpsd_pkg::SymDah;
      end
    end else if (dit_eff) begin
      sym_valid = reach2;
      sym       = mpsd_pkg::SymDit;
    end else if (dah_eff) begin
      sym_valid = reach4;
      sym       = mpsd_pkg::SymDah;
    end else if (reach2) begin
      if (last_sym_q == mpsd_pkg::LastChar) begin
        sym_valid = 1'b1;
        sym       = mpsd_pkg::SymWord;
      end else if (last_sym_q != mpsd_pkg::LastWord) begin
        sym_valid = 1'b1;
        sym       = mpsd_pkg::SymChar;
      end
    end
  end

  // Next state per accepted request
  always_comb begin
    started_d   = started_q;
    prev_dit_d  = prev_dit_q;
    prev_dah_d  = prev_dah_q;
    ticks_d     = ticks_q;
    last_sym_d  = last_sym_q;
    out_valid_d = out_valid_q && !out_ready_i;
    symbol_d    = symbol_q;

    if (in_accept) begin
      if (!started_q) begin
        // First sample only records the paddles
        started_d  = 1'b1;
        prev_dit_d = dit_paddle_i;
        prev_dah_d = dah_paddle_i;
        ticks_d    = '0;
      end else begin
        if (changed || sym_valid) begin
          prev_dit_d = dit_eff;
          prev_dah_d = dah_eff;
          ticks_d    = '0;
        end else begin
          ticks_d = elapsed;
        end
        if (sym_valid) begin
          last_sym_d  = {1'b0, sym};
          out_valid_d = 1'b1;
          symbol_d    = sym;
        end
      end
    end
  end

  // Hold the dit period
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      period_q <= mpsd_pkg::PeriodReset;
    end else if (cfg_we_i) begin
      period_q <= cfg_wdata_i;
    end
  end

  // Advance decoder state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      started_q   <= 1'b0;
      prev_dit_q  <= 1'b0;
      prev_dah_q  <= 1'b0;
      ticks_q     <= '0;
      last_sym_q  <= mpsd_pkg::LastNone;
      dit_lock_q  <= 1'b0;
      dah_lock_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      started_q   <= started_d;
      prev_dit_q  <= prev_dit_d;
      prev_dah_q  <= prev_dah_d;
      ticks_q     <= ticks_d;
      last_sym_q  <= last_sym_d;
      out_valid_q <= out_valid_d;
      if (in_accept && started_q) begin
        dit_lock_q <= dit_lock_d;
        dah_lock_q <= dah_lock_d;
      end
    end
  end

  // Result payload
  always_ff @(posedge clk_i) begin
    symbol_q <= symbol_d;
  end

`ifndef SYNTHESIS
  // Only one paddle can be locked out at a time
  a_single_lock: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(dit_lock_q && dah_lock_q))
    else $error("both lockout flags set");

  // Once started, the decoder never returns to the unstarted state
  a_started_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    started_q |=> started_q)
    else $error("started flag dropped");

  // The first sample never produces a symbol
  a_first_silent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_accept && !started_q) |=> !out_valid_o)
    else $error("symbol emitted on first sample");

  // An emitted word space is remembered as the last symbol
  a_word_tracked: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_accept && started_q && sym_valid && sym == mpsd_pkg::SymWord)
      |=> (last_sym_q == mpsd_pkg::LastWord && symbol_o == mpsd_pkg::SymWord))
    else $error("word space not tracked");
`endif

endmodule
